// File: sv/rx_frame_descriptor_ring_macros.svh
// Assertion macros shared by the receive descriptor ring RTL.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef RX_FRAME_DESCRIPTOR_RING_MACROS_SVH
`define RX_FRAME_DESCRIPTOR_RING_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfd: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfd: next-cycle check failed");

`endif

// File: sv/rfd_pkg.sv
// Shared constants, types and helpers of the receive descriptor ring.
// Used by the channel interfaces, the descriptor store and the top level.
package rfd_pkg;

    // Buffer geometry.
    localparam int BUFFER_BYTES = 1024;
    localparam int BLOCK_BYTES  = 256;
    localparam int SLOT_COUNT   = 8;

    // Fixed field widths of the channel words.
    localparam int REMAIN_W = 9;
    localparam int START_W  = 10;
    localparam int LEN_W    = 9;

    // Derived widths.
    localparam int SLOT_W  = $clog2(SLOT_COUNT);
    localparam int FILL_W  = $clog2(BUFFER_BYTES + BLOCK_BYTES + 2);
    localparam int CALC_W0 = (FILL_W > START_W) ? FILL_W : START_W;
    localparam int CALC_W1 = (CALC_W0 > LEN_W) ? CALC_W0 : LEN_W;
    localparam int CALC_W2 = (CALC_W1 > REMAIN_W) ? CALC_W1 : REMAIN_W;
    localparam int CALC_W  = CALC_W2 + 1;

    // Operation codes on the request channel.
    localparam logic FUNC_IDLE = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Write request into the descriptor store.
    typedef struct packed {
        logic                start_we;
        logic [SLOT_W-1:0]   start_addr;
        logic [START_W-1:0]  start_data;
        logic                end_we;
        logic [SLOT_W-1:0]   end_addr;
        logic [CALC_W-1:0]   end_data;
    } desc_wr_t;

    // Registered read data from the descriptor store.
    typedef struct packed {
        logic [START_W-1:0]  start;
        logic [CALC_W-1:0]   end_ofs;
        logic                end_set;
    } desc_rd_t;

    // Slot index that follows s around the ring.
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(SLOT_COUNT - 1))
            r = '0;
        else
            r = s + SLOT_W'(1);
        return r;
    endfunction

    // Start offset a slot holds after reset.
    function automatic logic [START_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
        logic [31:0] prod;
        prod = 32'(s) * 32'(BLOCK_BYTES);
        return prod[START_W-1:0];
    endfunction

endpackage

// File: sv/rfd_req_if.sv
// Request channel of the receive descriptor ring: operation and DMA remaining count.
// Depends on rfd_pkg for field widths.
interface rfd_req_if import rfd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                func;
    logic [REMAIN_W-1:0] remain;

    modport source (output valid, output func, output remain, input ready);
    modport sink   (input valid, input func, input remain, output ready);
endinterface

// File: sv/rfd_rsp_if.sv
// Response channel of the receive descriptor ring: DMA start and popped descriptor.
// Depends on rfd_pkg for field widths.
interface rfd_rsp_if import rfd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [START_W-1:0] next_dma_start;
    logic               frame_valid;
    logic [START_W-1:0] frame_start;
    logic [LEN_W-1:0]   frame_length;
    logic               ring_empty;

    modport source (output valid, output next_dma_start, output frame_valid,
                    output frame_start, output frame_length, output ring_empty,
                    input ready);
    modport sink   (input valid, input next_dma_start, input frame_valid,
                    input frame_start, input frame_length, input ring_empty,
                    output ready);
endinterface

// File: sv/rfd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module rfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: sv/rfd_desc_store.sv
// Descriptor store: start and end offset memories plus per-slot written marks.
// Depends on rfd_pkg and rfd_ram.
module rfd_desc_store import rfd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  desc_wr_t          wr,
    input  logic [SLOT_W-1:0] rd_addr,
    output desc_rd_t          rd
);

    logic [SLOT_COUNT-1:0] start_written_reg;
    logic [SLOT_COUNT-1:0] end_set_reg;
    logic                  start_written_q;
    logic                  end_set_q;
    logic [SLOT_W-1:0]     rd_addr_q;
    logic [START_W-1:0]    start_mem_q;
    logic [CALC_W-1:0]     end_mem_q;

    // Start offsets of the slots.
    rfd_ram #(.WIDTH(START_W), .DEPTH(SLOT_COUNT)) u_start_ram (
        .clk   (clk),
        .we    (wr.start_we),
        .waddr (wr.start_addr),
        .wdata (wr.start_data),
        .raddr (rd_addr),
        .rdata (start_mem_q)
    );

    // End offsets of the slots.
    rfd_ram #(.WIDTH(CALC_W), .DEPTH(SLOT_COUNT)) u_end_ram (
        .clk   (clk),
        .we    (wr.end_we),
        .waddr (wr.end_addr),
        .wdata (wr.end_data),
        .raddr (rd_addr),
        .rdata (end_mem_q)
    );

    // Per-slot marks; an unwritten start reads as the slot's reset offset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_written_reg <= '0;
            end_set_reg       <= '0;
            start_written_q   <= 1'b0;
            end_set_q         <= 1'b0;
            rd_addr_q         <= '0;
        end
        else
        begin
            if (wr.start_we)
            begin
                start_written_reg[wr.start_addr] <= 1'b1;
            end
            if (wr.end_we)
            begin
                end_set_reg[wr.end_addr] <= 1'b1;
            end
            start_written_q <= start_written_reg[rd_addr];
            end_set_q       <= end_set_reg[rd_addr];
            rd_addr_q       <= rd_addr;
        end
    end

    // Read data with reset values substituted.
    always_comb
    begin
        rd.start   = start_written_q ? start_mem_q : slot_base(rd_addr_q);
        rd.end_ofs = end_set_q ? end_mem_q : '0;
        rd.end_set = end_set_q;
    end

endmodule

// File: sv/rx_frame_descriptor_ring.sv
// Receive frame descriptor ring. Each request word is either an idle-line event carrying
// the DMA remaining count, or a pop of the oldest frame descriptor; each gives exactly one
// response word carrying the next DMA start offset and, for a pop, the frame's start,
// length, valid and empty flags. An idle-line event or an empty-ring pop goes straight to the
// output register; any other pop waits in S_POP for the registered read of the descriptor
// memories and a free output register. One word is in work at a time, and a new word is taken
// only when the output register is empty or its response is being taken in the same cycle.
`include "rx_frame_descriptor_ring_macros.svh"

module rx_frame_descriptor_ring import rfd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    rfd_req_if.sink   req,
    rfd_rsp_if.source rsp
);

    typedef enum logic {
        S_IDLE,
        S_POP
    } state_t;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0]   read_slot_reg, read_slot_next;
    logic [CALC_W-1:0]   fill_count_reg, fill_count_next;
    logic [START_W-1:0]  cur_start_reg, cur_start_next;
    logic                rsp_vld_reg, rsp_vld_next;
    logic [START_W-1:0]  next_dma_reg, next_dma_next;
    logic                fvalid_reg, fvalid_next;
    logic [START_W-1:0]  fstart_reg, fstart_next;
    logic [LEN_W-1:0]    flen_reg, flen_next;
    logic                empty_reg, empty_next;

    desc_wr_t            wr;
    desc_rd_t            rd;
    logic                req_fire;
    logic                out_free;
    logic [CALC_W-1:0]   full_len;
    logic [CALC_W-1:0]   remain_ext;
    logic [CALC_W-1:0]   frame_len;
    logic [CALC_W-1:0]   sum;
    logic                wrap;
    logic [SLOT_W-1:0]   ws_adv;
    logic [START_W-1:0]  new_start;
    logic [CALC_W-1:0]   pop_len;

    rfd_desc_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (read_slot_reg),
        .rd      (rd)
    );

    // Handshake: the output register is free when empty or being drained.
    assign out_free  = !rsp_vld_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign req_fire  = req.valid && req.ready;

    // Frame length and the placement of the next frame.
    always_comb
    begin
        full_len   = CALC_W'(BLOCK_BYTES + 1);
        remain_ext = CALC_W'(req.remain);
        frame_len  = (remain_ext > full_len) ? '0 : full_len - remain_ext;
        sum        = fill_count_reg + frame_len;
        wrap       = (sum > CALC_W'(BUFFER_BYTES)) ||
                     ((CALC_W'(BUFFER_BYTES) - sum) < CALC_W'(BLOCK_BYTES));
        ws_adv     = next_slot(write_slot_reg);
        new_start  = wrap ? '0 : sum[START_W-1:0];
        pop_len    = rd.end_ofs - CALC_W'(rd.start) + CALC_W'(1);
    end

    // Control and next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        fill_count_next = fill_count_reg;
        cur_start_next  = cur_start_reg;
        rsp_vld_next    = rsp_vld_reg && !rsp.ready;
        next_dma_next   = next_dma_reg;
        fvalid_next     = fvalid_reg;
        fstart_next     = fstart_reg;
        flen_next       = flen_reg;
        empty_next      = empty_reg;
        wr              = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.func == FUNC_IDLE)
                    begin
                        rsp_vld_next  = 1'b1;
                        fvalid_next   = 1'b0;
                        fstart_next   = '0;
                        flen_next     = '0;
                        empty_next    = 1'b0;
                        next_dma_next = cur_start_reg;
                        if (frame_len != '0)
                        begin
                            wr.end_we       = 1'b1;
                            wr.end_addr     = write_slot_reg;
                            wr.end_data     = sum - CALC_W'(1);
                            wr.start_we     = 1'b1;
                            wr.start_addr   = ws_adv;
                            wr.start_data   = new_start;
                            write_slot_next = ws_adv;
                            fill_count_next = wrap ? '0 : sum;
                            cur_start_next  = new_start;
                            next_dma_next   = new_start;
                        end
                    end
                    else if (read_slot_reg == write_slot_reg)
                    begin
                        rsp_vld_next  = 1'b1;
                        fvalid_next   = 1'b0;
                        fstart_next   = '0;
                        flen_next     = '0;
                        empty_next    = 1'b1;
                        next_dma_next = cur_start_reg;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    rsp_vld_next   = 1'b1;
                    fvalid_next    = rd.end_set;
                    fstart_next    = rd.end_set ? rd.start : '0;
                    flen_next      = rd.end_set ? pop_len[LEN_W-1:0] : '0;
                    empty_next     = 1'b0;
                    next_dma_next  = cur_start_reg;
                    read_slot_next = next_slot(read_slot_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            fill_count_reg <= '0;
            cur_start_reg  <= '0;
            rsp_vld_reg    <= 1'b0;
            next_dma_reg   <= '0;
            fvalid_reg     <= 1'b0;
            fstart_reg     <= '0;
            flen_reg       <= '0;
            empty_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            fill_count_reg <= fill_count_next;
            cur_start_reg  <= cur_start_next;
            rsp_vld_reg    <= rsp_vld_next;
            next_dma_reg   <= next_dma_next;
            fvalid_reg     <= fvalid_next;
            fstart_reg     <= fstart_next;
            flen_reg       <= flen_next;
            empty_reg      <= empty_next;
        end
    end

    assign rsp.valid          = rsp_vld_reg;
    assign rsp.next_dma_start = next_dma_reg;
    assign rsp.frame_valid    = fvalid_reg;
    assign rsp.frame_start    = fstart_reg;
    assign rsp.frame_length   = flen_reg;
    assign rsp.ring_empty     = empty_reg;

    // An empty-ring response never carries a frame.
    `RFD_ASSERT_NOW(a_empty_no_frame, rsp_vld_reg && empty_reg, !fvalid_reg && flen_reg == '0)
    // No request is taken while a descriptor read is in flight.
    `RFD_ASSERT_NOW(a_pop_blocks_req, state_reg == S_POP, !req.ready)
    // A wrapping frame end restarts the buffer at offset zero.
    `RFD_ASSERT_NEXT(a_wrap_clears_fill, req_fire && req.func == FUNC_IDLE && frame_len != '0 && wrap, fill_count_reg == '0 && cur_start_reg == '0)

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the receive frame descriptor ring: directed and random idle-line and pop words.
// Depends on rfd_pkg, rfd_req_if, rfd_rsp_if and rx_frame_descriptor_ring; checks every response.
module tb_top;
    import rfd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 1020;
    localparam int MAX_PRINTS   = 30;

    // One response word as the ring should deliver it.
    typedef struct packed {
        logic [START_W-1:0] next_dma_start;
        logic               frame_valid;
        logic [START_W-1:0] frame_start;
        logic [LEN_W-1:0]   frame_length;
        logic               ring_empty;
    } ring_word_t;

    logic clk = 1'b0;
    logic rst_n;

    rfd_req_if req_if ();
    rfd_rsp_if rsp_if ();

    rx_frame_descriptor_ring u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Mirror of the descriptor ring state.
    int  desc_start [SLOT_COUNT];
    int  desc_end [SLOT_COUNT];
    bit  desc_end_set [SLOT_COUNT];
    int  wr_slot;
    int  rd_slot;
    int  fill_bytes;

    ring_word_t pending_words [$];
    int  mismatches = 0;
    int  words_sent = 0;
    int  cycle_count = 0;
    int  idle_events = 0;
    int  pop_events = 0;
    int  empty_pops = 0;
    int  frames_popped = 0;
    int  ring_wraps = 0;
    bit  calm = 1'b0;

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run length guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d words outstanding.",
                     cycle_count, pending_words.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Work out the response to one word and update the mirrored ring state.
    function automatic ring_word_t predict_ring_word(input logic op, input logic [8:0] rem);
        ring_word_t w;
        int         len;
        w = '0;
        if (op == FUNC_IDLE)
        begin
            len = (int'(rem) > BLOCK_BYTES + 1) ? 0 : BLOCK_BYTES + 1 - int'(rem);
            if (len != 0)
            begin
                desc_end[wr_slot] = fill_bytes + len - 1;
                desc_end_set[wr_slot] = 1'b1;
                fill_bytes += len;
                wr_slot = (wr_slot + 1) % SLOT_COUNT;
                if (fill_bytes <= BUFFER_BYTES && BUFFER_BYTES - fill_bytes >= BLOCK_BYTES)
                    desc_start[wr_slot] = fill_bytes;
                else
                begin
                    desc_start[wr_slot] = 0;
                    fill_bytes = 0;
                    ring_wraps++;
                end
            end
        end
        else if (rd_slot == wr_slot)
            w.ring_empty = 1'b1;
        else
        begin
            if (desc_end_set[rd_slot])
            begin
                w.frame_valid  = 1'b1;
                w.frame_start  = desc_start[rd_slot][START_W-1:0];
                len = desc_end[rd_slot] - desc_start[rd_slot] + 1;
                w.frame_length = len[LEN_W-1:0];
            end
            rd_slot = (rd_slot + 1) % SLOT_COUNT;
        end
        w.next_dma_start = desc_start[wr_slot][START_W-1:0];
        return w;
    endfunction

    // Prints one mismatch line, up to a cap, and counts every one.
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Predict on each accepted request word, then check each accepted response word.
    always @(posedge clk)
    begin
        ring_word_t w;
        if (rst_n && req_if.valid && req_if.ready)
        begin
            w = predict_ring_word(req_if.func, req_if.remain);
            pending_words.push_back(w);
            if (req_if.func == FUNC_POP)
            begin
                pop_events++;
                empty_pops += w.ring_empty;
                frames_popped += w.frame_valid;
            end
            else
                idle_events++;
        end
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_words.size() == 0)
                report_mismatch("unexpected response word", 1, 0);
            else
            begin
                w = pending_words.pop_front();
                if (rsp_if.next_dma_start !== w.next_dma_start)
                    report_mismatch("next_dma_start", rsp_if.next_dma_start, w.next_dma_start);
                if (rsp_if.frame_valid !== w.frame_valid)
                    report_mismatch("frame_valid", rsp_if.frame_valid, w.frame_valid);
                if (rsp_if.frame_start !== w.frame_start)
                    report_mismatch("frame_start", rsp_if.frame_start, w.frame_start);
                if (rsp_if.frame_length !== w.frame_length)
                    report_mismatch("frame_length", rsp_if.frame_length, w.frame_length);
                if (rsp_if.ring_empty !== w.ring_empty)
                    report_mismatch("ring_empty", rsp_if.ring_empty, w.ring_empty);
            end
        end
    end

    // Response ready stalls at random unless the calm stretch is on.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
            rsp_if.ready <= calm || ($urandom_range(99) >= 15);
    end

    // Sends one request word, at times after a random gap, and waits until it is taken.
    task automatic send_word(input logic op, input logic [8:0] rem);
        @(negedge clk);
        if (!calm && $urandom_range(99) < 15)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(negedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.func   <= op;
        req_if.remain <= rem;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Stops sending and waits until every expected response word has come.
    task automatic drain_responses();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
    endtask

    // Pop on an empty ring right after reset.
    task automatic test_empty_pop();
        send_word(FUNC_POP, 9'd0);
    endtask

    // Three full blocks fill to exactly three quarters; a longest frame then runs past the buffer.
    task automatic test_fill_overflow();
        repeat (3) send_word(FUNC_IDLE, 9'd1);
        send_word(FUNC_IDLE, 9'd0);
        drain_responses();
    endtask

    // Pop the four frames back, then one more on the now empty ring.
    task automatic test_pop_frames();
        repeat (5) send_word(FUNC_POP, 9'h1FF);
    endtask

    // Remaining counts that give no frame, up to the all-ones count.
    task automatic test_zero_length();
        send_word(FUNC_IDLE, 9'd257);
        send_word(FUNC_IDLE, 9'd258);
        send_word(FUNC_IDLE, 9'h1FF);
    endtask

    // Shortest frames and a mid-size one, then a pop.
    task automatic test_short_frames();
        send_word(FUNC_IDLE, 9'd256);
        send_word(FUNC_IDLE, 9'd255);
        send_word(FUNC_IDLE, 9'd128);
        send_word(FUNC_POP, 9'd0);
    endtask

    // Writes lap the unread frames; pops then read stale end marks.
    task automatic test_overrun();
        repeat (9) send_word(FUNC_IDLE, 9'd200);
        repeat (3) send_word(FUNC_POP, 9'd0);
    endtask

    // Mostly write bursts followed by pops, with overrun bursts and random noise.
    task automatic test_random_traffic(input int count);
        int  first;
        int  mode;
        int  burst;
        int  i;
        bit  drained;
        logic [8:0] rem;
        first = words_sent;
        drained = 1'b0;
        while (words_sent - first < count)
        begin
            calm = (words_sent - first >= 400) && (words_sent - first < 560);
            if (!drained && words_sent - first >= count / 2)
            begin
                drain_responses();
                drained = 1'b1;
            end
            mode = $urandom_range(99);
            if (mode < 80)
            begin
                burst = (mode < 68) ? $urandom_range(6, 1) : $urandom_range(12, 8);
                for (i = 0; i < burst; i++)
                begin
                    if ($urandom_range(99) < 10)
                        rem = 9'($urandom_range(511, 257));
                    else if ($urandom_range(99) < 15)
                        rem = 9'($urandom_range(1, 0));
                    else
                        rem = 9'($urandom_range(256, 0));
                    send_word(FUNC_IDLE, rem);
                end
                burst = $urandom_range(burst + 1, (burst > 2) ? burst - 2 : 1);
                for (i = 0; i < burst; i++)
                    send_word(FUNC_POP, 9'($urandom_range(511, 0)));
            end
            else
            begin
                burst = $urandom_range(4, 1);
                for (i = 0; i < burst; i++)
                    send_word(logic'($urandom_range(1, 0)), 9'($urandom_range(511, 0)));
            end
        end
        calm = 1'b0;
    endtask

    // Reset, run the tests in turn, then wait out the last responses.
    initial
    begin
        int i;
        for (i = 0; i < SLOT_COUNT; i++)
        begin
            desc_start[i] = i * BLOCK_BYTES;
            desc_end[i] = 0;
            desc_end_set[i] = 1'b0;
        end
        wr_slot = 0;
        rd_slot = 0;
        fill_bytes = 0;
        rst_n = 1'b0;
        req_if.valid  = 1'b0;
        req_if.func   = FUNC_IDLE;
        req_if.remain = '0;
        rsp_if.ready  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_pop();
        test_fill_overflow();
        test_pop_frames();
        test_zero_length();
        test_short_frames();
        test_overrun();
        test_random_traffic(RANDOM_WORDS);

        drain_responses();
        repeat (10) @(posedge clk);

        $display("Sent %0d words: %0d idle-line events, %0d pops (%0d empty, %0d frames).",
                 words_sent, idle_events, pop_events, empty_pops, frames_popped);
        $display("The buffer wrapped %0d times; %0d mismatches in %0d cycles.",
                 ring_wraps, mismatches, cycle_count);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/rfd_pkg.sv
sv/rfd_req_if.sv
sv/rfd_rsp_if.sv
sv/rfd_ram.sv
sv/rfd_desc_store.sv
sv/rx_frame_descriptor_ring.sv
test/tb_top.sv
